@@ sv/set_assoc_cache_tag_controller_defines.svh @@
// assertion macros shared by the cache tag controller modules
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, off during reset
`define SACTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sactc: same-cycle check failed");

// next-cycle implication, off during reset
`define SACTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sactc: next-cycle check failed");

`else

`define SACTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SACTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/sactc_pkg.sv @@
// shared types and constants of the cache tag controller
`timescale 1ns / 1ps

package sactc_pkg;

  // fixed field widths
  localparam int ADDR_W    = 48;
  localparam int VICTIM_W  = 42;
  localparam int CFG_IDX_W = 2;

  // access kinds
  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } sactc_func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLACE_FIFO = 2'd0,
    CFG_WRITE_BACK   = 2'd1
  } sactc_cfg_idx_e;

  // live policy settings
  typedef struct packed {
    logic replace_fifo;
    logic write_back;
  } sactc_cfg_t;

  // per-item status flags
  typedef struct packed {
    logic hit;
    logic fill_read;
    logic mem_write;
    logic is_writeback;
  } sactc_result_t;

endpackage

@@ sv/set_assoc_cache_tag_controller.sv @@
// top level of the set-associative cache tag and replacement controller
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------
//  access   | in        | in_valid_i/in_ready_o  | func_i, address_i
//  result   | out       | out_valid_o/out_ready_i| hit_o, fill_read_o, mem_write_o,
//           |           |                        | is_writeback_o, victim_block_o
//  config   | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one access per cycle unless the result channel or the sweep stalls it; each access
// goes through the lookup stage (set row read, way compare) and then the result register
// after reset the set memory is swept clear with in_ready_o low
// a stalled result holds one access in the lookup stage and one in the result register
// SETS and LINE_BYTES must be powers of two; the block does not check it
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_controller_defines.svh"

module set_assoc_cache_tag_controller
  import sactc_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 8,
  parameter int LINE_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // access channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [ADDR_W-1:0]    address_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic                 fill_read_o,
  output logic                 mem_write_o,
  output logic                 is_writeback_o,
  output logic [VICTIM_W-1:0]  victim_block_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int TAG_W  = ADDR_W - OFF_W;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = WAYS * (TAG_W + 2 + RANK_W);

  sactc_cfg_t                  cfg_q;
  logic                        s1_valid_q;
  sactc_func_e                 s1_func_q;
  logic [TAG_W-1:0]            s1_tag_q;
  logic                        out_valid_q;
  sactc_result_t               res_q;
  logic [VICTIM_W-1:0]         victim_q;

  logic                        in_fire;
  logic                        s1_adv;
  logic                        store_busy;
  logic [TAG_W-1:0]            in_tag;
  logic [SET_W-1:0]            in_set;
  logic [SET_W-1:0]            s1_set;
  logic [ROW_W-1:0]            rd_row;
  logic [ROW_W-1:0]            wr_row;
  logic [WAYS-1:0][TAG_W-1:0]  rd_tags;
  logic [WAYS-1:0]             rd_valid;
  logic [WAYS-1:0]             rd_dirty;
  logic [WAYS-1:0][RANK_W-1:0] rd_rank;
  logic [WAYS-1:0][TAG_W-1:0]  wr_tags;
  logic [WAYS-1:0]             wr_valid;
  logic [WAYS-1:0]             wr_dirty;
  logic [WAYS-1:0][RANK_W-1:0] wr_rank;
  sactc_result_t               res_d;
  logic [VICTIM_W-1:0]         victim_d;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (sactc_cfg_idx_e'(cfg_index_i))
        CFG_REPLACE_FIFO: cfg_q.replace_fifo <= cfg_data_i;
        CFG_WRITE_BACK:   cfg_q.write_back   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake and stage advance
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !store_busy && (!s1_valid_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;

  // block address and set index
  assign in_tag = address_i[ADDR_W-1:OFF_W];
  assign in_set = (SETS > 1) ? in_tag[SET_W-1:0] : '0;
  assign s1_set = (SETS > 1) ? s1_tag_q[SET_W-1:0] : '0;

  // lookup stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= sactc_func_e'(func_i);
      s1_tag_q  <= in_tag;
    end
  end

  // set row storage
  sactc_set_store #(
    .SETS  (SETS),
    .ROW_W (ROW_W),
    .SET_W (SET_W)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_set_i (in_set),
    .rd_row_o (rd_row),
    .wr_en_i  (s1_adv),
    .wr_set_i (s1_set),
    .wr_row_i (wr_row),
    .busy_o   (store_busy)
  );

  assign {rd_rank, rd_dirty, rd_valid, rd_tags} = rd_row;
  assign wr_row = {wr_rank, wr_dirty, wr_valid, wr_tags};

  // hit check and replacement
  sactc_way_logic #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W),
    .WAY_W  (WAY_W)
  ) u_ways (
    .cfg_i    (cfg_q),
    .func_i   (s1_func_q),
    .tag_i    (s1_tag_q),
    .tags_i   (rd_tags),
    .valid_i  (rd_valid),
    .dirty_i  (rd_dirty),
    .rank_i   (rd_rank),
    .tags_o   (wr_tags),
    .valid_o  (wr_valid),
    .dirty_o  (wr_dirty),
    .rank_o   (wr_rank),
    .res_o    (res_d),
    .victim_o (victim_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q    <= res_d;
      victim_q <= victim_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = res_q.hit;
  assign fill_read_o    = res_q.fill_read;
  assign mem_write_o    = res_q.mem_write;
  assign is_writeback_o = res_q.is_writeback;
  assign victim_block_o = victim_q;

  `SACTC_ASSERT_IMP(a_wb_on_miss_only, clk_i, rst_ni, out_valid_q && res_q.is_writeback, res_q.mem_write && res_q.fill_read && !res_q.hit)
  `SACTC_ASSERT_IMP(a_victim_zero, clk_i, rst_ni, out_valid_q && !res_q.is_writeback, victim_q == '0)
  `SACTC_ASSERT_IMP(a_hit_or_fill, clk_i, rst_ni, out_valid_q, res_q.hit != res_q.fill_read)
  `SACTC_ASSERT_NXT(a_stalled_lookup_holds, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_tag_q))

endmodule

@@ sv/sactc_way_logic.sv @@
// per-set lookup, victim choice and replacement update for one item
`timescale 1ns / 1ps

module sactc_way_logic
  import sactc_pkg::*;
#(
  parameter int WAYS   = 8,
  parameter int TAG_W  = 42,
  parameter int RANK_W = 3,
  parameter int WAY_W  = 3
) (
  input  sactc_cfg_t                    cfg_i,
  input  sactc_func_e                   func_i,
  input  logic [TAG_W-1:0]              tag_i,
  input  logic [WAYS-1:0][TAG_W-1:0]    tags_i,
  input  logic [WAYS-1:0]               valid_i,
  input  logic [WAYS-1:0]               dirty_i,
  input  logic [WAYS-1:0][RANK_W-1:0]   rank_i,
  output logic [WAYS-1:0][TAG_W-1:0]    tags_o,
  output logic [WAYS-1:0]               valid_o,
  output logic [WAYS-1:0]               dirty_o,
  output logic [WAYS-1:0][RANK_W-1:0]   rank_o,
  output sactc_result_t                 res_o,
  output logic [VICTIM_W-1:0]           victim_o
);

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  logic              tag_hit;
  logic [WAY_W-1:0]  hit_way;
  logic              empty_found;
  logic [WAY_W-1:0]  empty_way;
  logic [WAY_W-1:0]  old_way;
  logic [RANK_W-1:0] old_rank;
  logic [WAY_W-1:0]  sel_way;
  logic [RANK_W:0]   age_below;
  logic              age_en;
  logic              wb_evict;

  // tag match, first empty way, oldest way (highest index wins ties)
  always_comb begin
    tag_hit     = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    old_way     = '0;
    old_rank    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!tag_hit && valid_i[w] && (tags_i[w] == tag_i)) begin
        tag_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!empty_found && !valid_i[w]) begin
        empty_found = 1'b1;
        empty_way   = WAY_W'(w);
      end
      if (rank_i[w] >= old_rank) begin
        old_rank = rank_i[w];
        old_way  = WAY_W'(w);
      end
    end
  end

  // way that this item lands in
  assign sel_way = tag_hit ? hit_way : (empty_found ? empty_way : old_way);

  // fifo hits leave the order alone; a miss ages every other valid way
  assign age_en    = !tag_hit || !cfg_i.replace_fifo;
  assign age_below = tag_hit ? {1'b0, rank_i[hit_way]} : (RANK_W + 1)'(WAYS);

  assign wb_evict = !tag_hit && !empty_found && cfg_i.write_back && dirty_i[sel_way];

  // updated set contents
  always_comb begin
    tags_o  = tags_i;
    valid_o = valid_i;
    dirty_o = dirty_i;
    rank_o  = rank_i;
    if (age_en) begin
      for (int w = 0; w < WAYS; w++) begin
        if ((WAY_W'(w) != sel_way) && valid_i[w] && ({1'b0, rank_i[w]} < age_below) &&
            (rank_i[w] < RANK_MAX)) begin
          rank_o[w] = rank_i[w] + 1'b1;
        end
      end
      rank_o[sel_way] = '0;
    end
    if (!tag_hit) begin
      tags_o[sel_way]  = tag_i;
      valid_o[sel_way] = 1'b1;
      dirty_o[sel_way] = 1'b0;
    end
    if ((func_i == FUNC_WRITE) && cfg_i.write_back) begin
      dirty_o[sel_way] = 1'b1;
    end
  end

  // status flags and victim address
  always_comb begin
    res_o.hit          = tag_hit;
    res_o.fill_read    = !tag_hit;
    res_o.is_writeback = wb_evict;
    res_o.mem_write    = wb_evict || ((func_i == FUNC_WRITE) && !cfg_i.write_back);
    victim_o           = wb_evict ? VICTIM_W'(tags_i[sel_way]) : '0;
  end

endmodule

@@ sv/sactc_set_store.sv @@
// per-set row memory with a clearing sweep after reset and same-set forwarding
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_controller_defines.svh"

module sactc_set_store #(
  parameter int SETS  = 64,
  parameter int ROW_W = 8,
  parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SET_W-1:0] rd_set_i,
  output logic [ROW_W-1:0] rd_row_o,
  input  logic             wr_en_i,
  input  logic [SET_W-1:0] wr_set_i,
  input  logic [ROW_W-1:0] wr_row_i,
  output logic             busy_o
);

  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  logic [ROW_W-1:0] mem_q [SETS];
  logic [ROW_W-1:0] rd_q;
  logic [ROW_W-1:0] fwd_row_q;
  logic             fwd_q;
  logic             clr_busy_q;
  logic [SET_W-1:0] clr_idx_q;
  logic             mem_we;
  logic [SET_W-1:0] mem_wa;
  logic [ROW_W-1:0] mem_wd;

  // clearing sweep owns the write port until it is done
  assign mem_we = clr_busy_q || wr_en_i;
  assign mem_wa = clr_busy_q ? clr_idx_q : wr_set_i;
  assign mem_wd = clr_busy_q ? '0 : wr_row_i;

  // row memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_set_i];
    end
  end

  // row written at the same edge as the read of that set
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_row_q <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_set_i == rd_set_i);
    end
  end

  assign rd_row_o = fwd_q ? fwd_row_q : rd_q;

  // clearing sweep, one set per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == LAST_SET) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = clr_busy_q;

  `SACTC_ASSERT_IMP(a_idle_while_clearing, clk_i, rst_ni, clr_busy_q, !rd_en_i && !wr_en_i)
  `SACTC_ASSERT_NXT(a_same_set_forwards, clk_i, rst_ni, rd_en_i && wr_en_i && (rd_set_i == wr_set_i), fwd_q)
  `SACTC_ASSERT_IMP(a_sweep_covers_all, clk_i, rst_ni, $fell(clr_busy_q), $past(clr_idx_q) == LAST_SET)

endmodule

@@ verif/tb_set_assoc_cache_tag_controller.sv @@
// self-checking testbench for the set-associative cache tag controller
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_controller;
  import sactc_pkg::*;

  localparam int SET_COUNT    = 64;
  localparam int NUM_WAYS     = 8;
  localparam int LINE_SIZE    = 64;
  localparam int NUM_LINES    = SET_COUNT * NUM_WAYS;
  localparam int OFFS_W       = $clog2(LINE_SIZE);
  localparam int SET_W        = $clog2(SET_COUNT);
  localparam int BLOCK_W      = ADDR_W - OFFS_W;
  localparam int HIGH_W       = BLOCK_W - SET_W;
  localparam int POOL_TAGS    = 12;
  localparam int POOL_SETS    = 4;
  localparam int DRAIN_CYCLES = 4;
  localparam int TIMEOUT_NS   = 200_000;

  // expected flags and victim of one access
  typedef struct packed {
    sactc_result_t       flags;
    logic [VICTIM_W-1:0] victim;
  } access_outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  sactc_func_e         func_i = FUNC_READ;
  logic [ADDR_W-1:0]   address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                hit_o;
  logic                fill_read_o;
  logic                mem_write_o;
  logic                is_writeback_o;
  logic [VICTIM_W-1:0] victim_block_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  sactc_cfg_idx_e      cfg_index_i = CFG_REPLACE_FIFO;
  logic                cfg_data_i = 1'b0;

  // shadow copy of the tag store and policy
  logic [BLOCK_W-1:0]  line_block [NUM_LINES];
  bit                  line_live  [NUM_LINES];
  bit                  line_dirty [NUM_LINES];
  logic [2:0]          line_rank  [NUM_LINES];
  bit                  pol_fifo = 1'b0;
  bit                  pol_write_back = 1'b0;

  access_outcome_t     predicted_outcomes [$];
  int                  mismatch_count = 0;
  int                  result_count = 0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  rx_hold_left = 0;
  logic [HIGH_W-1:0]   tag_pool [POOL_TAGS];
  logic [SET_W-1:0]    set_pool [POOL_SETS];

  set_assoc_cache_tag_controller #(
    .SETS      (SET_COUNT),
    .WAYS      (NUM_WAYS),
    .LINE_BYTES(LINE_SIZE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .fill_read_o   (fill_read_o),
    .mem_write_o   (mem_write_o),
    .is_writeback_o(is_writeback_o),
    .victim_block_o(victim_block_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // age the valid ways of a set that are younger than a given rank
  function automatic void age_set(int base, int keep, int below);
    int w;
    for (w = 0; w < NUM_WAYS; w++) begin
      if (w != keep && line_live[base + w] && line_rank[base + w] < below &&
          line_rank[base + w] < NUM_WAYS - 1)
        line_rank[base + w] += 1;
    end
  endfunction

  // lookup, replacement and write policy of one access
  function automatic access_outcome_t predict_access(sactc_func_e kind,
                                                     logic [ADDR_W-1:0] addr);
    logic [BLOCK_W-1:0] blk;
    int                 base;
    int                 way;
    int                 w;
    int                 oldest_rank;
    bit                 empty_found;
    access_outcome_t    res;
    blk  = addr[ADDR_W-1:OFFS_W];
    base = int'(blk[SET_W-1:0]) * NUM_WAYS;
    res  = '0;
    way  = -1;
    for (w = 0; w < NUM_WAYS; w++) begin
      if (way < 0 && line_live[base + w] && line_block[base + w] == blk)
        way = w;
    end
    if (way >= 0) begin
      res.flags.hit = 1'b1;
      // only lru refreshes on a hit
      if (!pol_fifo) begin
        age_set(base, way, line_rank[base + way]);
        line_rank[base + way] = '0;
      end
    end else begin
      res.flags.fill_read = 1'b1;
      way = 0;
      oldest_rank = 0;
      empty_found = 1'b0;
      // first empty way, else the oldest, ties to the highest way
      for (w = 0; w < NUM_WAYS; w++) begin
        if (!empty_found) begin
          if (!line_live[base + w]) begin
            way = w;
            empty_found = 1'b1;
          end else if (line_rank[base + w] >= oldest_rank) begin
            oldest_rank = line_rank[base + w];
            way = w;
          end
        end
      end
      if (!empty_found && pol_write_back && line_dirty[base + way]) begin
        res.flags.mem_write    = 1'b1;
        res.flags.is_writeback = 1'b1;
        res.victim             = line_block[base + way];
      end
      age_set(base, way, NUM_WAYS);
      line_block[base + way] = blk;
      line_live[base + way]  = 1'b1;
      line_dirty[base + way] = 1'b0;
      line_rank[base + way]  = '0;
    end
    if (kind == FUNC_WRITE) begin
      if (!pol_write_back)
        res.flags.mem_write = 1'b1;
      else
        line_dirty[base + way] = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("result %0d: %s got %0h expected %0h", result_count, field, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    access_outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_outcomes.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = predicted_outcomes.pop_front();
        if (hit_o !== want.flags.hit)
          report_mismatch("hit", hit_o, want.flags.hit);
        if (fill_read_o !== want.flags.fill_read)
          report_mismatch("fill_read", fill_read_o, want.flags.fill_read);
        if (mem_write_o !== want.flags.mem_write)
          report_mismatch("mem_write", mem_write_o, want.flags.mem_write);
        if (is_writeback_o !== want.flags.is_writeback)
          report_mismatch("is_writeback", is_writeback_o, want.flags.is_writeback);
        if (victim_block_o !== want.victim)
          report_mismatch("victim_block", victim_block_o, want.victim);
      end
      result_count++;
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i  <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // offer one item after an optional random gap, predict on acceptance
  task automatic send_access(sactc_func_e kind, logic [ADDR_W-1:0] addr);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= kind;
    address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_outcomes.push_back(predict_access(kind, addr));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one register write, valid left high for a following write
  task automatic write_policy(sactc_cfg_idx_e idx, logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REPLACE_FIFO: pol_fifo = val;
      CFG_WRITE_BACK:   pol_write_back = val;
      default: ;
    endcase
  endtask

  task automatic set_policy(logic fifo, logic wb);
    write_policy(CFG_REPLACE_FIFO, fifo);
    write_policy(CFG_WRITE_BACK, wb);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] make_addr(int set_idx, int tag_hi, int offs);
    return {HIGH_W'(tag_hi), SET_W'(set_idx), OFFS_W'(offs)};
  endfunction

  // mostly a few crowded sets with a small tag pool, some fully random noise
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 99) < 15)
      return {16'($urandom), $urandom};
    return {tag_pool[$urandom_range(0, POOL_TAGS - 1)],
            set_pool[$urandom_range(0, POOL_SETS - 1)], OFFS_W'($urandom)};
  endfunction

  // empty ways must not match tag zero, address extremes, write-through writes
  task automatic test_empty_and_extremes();
    set_policy(1'b0, 1'b0);
    send_access(FUNC_READ, '0);
    send_access(FUNC_READ, make_addr(0, 0, LINE_SIZE - 1));
    send_access(FUNC_WRITE, '0);
    send_access(FUNC_WRITE, '1);
    send_access(FUNC_READ, '1);
  endtask

  // fill one set dirty, lru refresh, dirty evictions on read and write misses
  task automatic test_lru_write_back();
    int t;
    wait_results_drained();
    set_policy(1'b0, 1'b1);
    for (t = 1; t <= NUM_WAYS; t++)
      send_access(FUNC_WRITE, make_addr(5, t, 0));
    send_access(FUNC_READ, make_addr(5, 1, 8));
    send_access(FUNC_READ, make_addr(5, 9, 0));
    send_access(FUNC_WRITE, make_addr(5, 10, LINE_SIZE - 1));
  endtask

  // dirty lines left over from write-back are dropped in write-through
  task automatic test_dirty_dropped();
    wait_results_drained();
    set_policy(1'b0, 1'b0);
    send_access(FUNC_READ, make_addr(5, 11, 0));
    send_access(FUNC_WRITE, make_addr(5, 12, 4));
  endtask

  // fifo keeps order on hits, ranks carried over from lru
  task automatic test_fifo_order();
    wait_results_drained();
    set_policy(1'b1, 1'b1);
    send_access(FUNC_READ, make_addr(5, 6, 0));
    send_access(FUNC_WRITE, make_addr(5, 7, 0));
    send_access(FUNC_READ, make_addr(5, 13, 0));
    send_access(FUNC_READ, make_addr(5, 14, 0));
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, logic fifo, logic wb, int n);
    int i;
    wait_results_drained();
    set_policy(fifo, wb);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (i = 2; i < POOL_TAGS; i++)
      tag_pool[i] = {4'($urandom), $urandom};
    for (i = 0; i < POOL_SETS; i++)
      set_pool[i] = SET_W'($urandom);
    for (i = 0; i < n; i++)
      send_access($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, pick_address());
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    int i;
    wait_results_drained();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    rx_hold_left <= 80;
    for (i = 0; i < 30; i++)
      send_access($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, pick_address());
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 28;
    rx_idle_pct <= 57;
    test_empty_and_extremes();
    test_lru_write_back();
    test_dirty_dropped();
    test_fifo_order();
    test_random_traffic(28, 57, 1'b0, 1'b1, 90);
    test_random_traffic(57, 28, 1'b1, 1'b1, 90);
    test_random_traffic(0, 0, 1'b1, 1'b0, 90);
    test_random_traffic(0, 0, 1'b0, 1'b0, 90);
    test_backpressure();
    wait_results_drained();
    if (mismatch_count == 0)
      $display("PASS set_assoc_cache_tag_controller");
    else
      $display("FAIL set_assoc_cache_tag_controller");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL set_assoc_cache_tag_controller");
    $finish;
  end

endmodule
